// ----- rtl/core/nat_pkg.sv -----
// nat_pkg: shared types, codes and name helpers for the name alias table.
// No dependencies; imported by every module of the block.
package nat_pkg;

  localparam int unsigned NAME_W            = 64;
  localparam int unsigned NAME_CHARS        = NAME_W / 8;
  localparam int unsigned TABLE_ENTRIES_DEF = 8;
  localparam int unsigned NAME_BYTES_DEF    = 8;

  typedef enum logic {
    OP_SET    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    OUT_RENAMED  = 3'd0,
    OUT_UPDATED  = 3'd1,
    OUT_APPENDED = 3'd2,
    OUT_REPLACED = 3'd3,
    OUT_NONE     = 3'd4
  } outcome_e;

  typedef struct packed {
    op_e               op;
    logic [NAME_W-1:0] key;
    logic [NAME_W-1:0] disp;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [NAME_W-1:0] result_name;
    outcome_e          set_outcome;
  } result_t;

  // Clear every byte after the first zero byte.
  function automatic logic [NAME_W-1:0] canon_name(logic [NAME_W-1:0] w);
    logic [NAME_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int b = 0; b < NAME_CHARS; b++) begin
      alive = alive & (w[8*b +: 8] != 8'h00);
      if (alive) begin
        r[8*b +: 8] = w[8*b +: 8];
      end
    end
    return r;
  endfunction

  // Bytes kept in a stored name: all but the top one of nbytes.
  function automatic logic [NAME_W-1:0] store_mask(int unsigned nbytes);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int unsigned b = 0; b < NAME_CHARS; b++) begin
      if (b + 1 < nbytes) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/nat_in_reg.sv -----
// nat_in_reg: input word register; canonicalises both names on capture.
// Depends on nat_pkg.
module nat_in_reg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic                    operation_i,
  input  logic [nat_pkg::NAME_W-1:0] key_name_i,
  input  logic [nat_pkg::NAME_W-1:0] display_name_i,
  input  logic                    take_i,
  output logic                    vld_o,
  output nat_pkg::item_t          item_o
);
  import nat_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  load;

  assign stall_o = vld_q && !take_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.op   <= op_e'(operation_i);
      item_q.key  <= canon_name(key_name_i);
      item_q.disp <= canon_name(display_name_i);
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/core/nat_table.sv -----
// nat_table: alias entries, parallel key/display compare and update decision.
// Depends on nat_pkg.
module nat_table #(
  parameter int unsigned TABLE_ENTRIES = nat_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned NAME_BYTES    = nat_pkg::NAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  nat_pkg::item_t   item_i,
  output nat_pkg::result_t res_o
);
  import nat_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [NAME_W-1:0] KEEP_MASK = store_mask(NAME_BYTES);

  logic [NAME_W-1:0] key_q  [TABLE_ENTRIES];
  logic [NAME_W-1:0] disp_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  rp_q, rp_d;

  logic [TABLE_ENTRIES-1:0] ent_vld, key_hit, disp_hit, key_first, disp_first, ins_sel;
  logic [TABLE_ENTRIES-1:0] wr_key, wr_disp;
  logic [NAME_W-1:0]        new_key, new_disp;
  logic                     full;

  assign full     = (cnt_q == CNT_W'(TABLE_ENTRIES));
  assign new_key  = item_i.key & KEEP_MASK;
  assign new_disp = item_i.disp & KEEP_MASK;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      ent_vld[i]  = CNT_W'(i) < cnt_q;
      key_hit[i]  = ent_vld[i] && (key_q[i] == item_i.key);
      disp_hit[i] = ent_vld[i] && (disp_q[i] == item_i.key);
      ins_sel[i]  = full ? (IDX_W'(i) == rp_q) : (CNT_W'(i) == cnt_q);
    end
    key_first  = key_hit & (~key_hit + TABLE_ENTRIES'(1));
    disp_first = disp_hit & (~disp_hit + TABLE_ENTRIES'(1));
  end

  always_comb begin
    res_o.found       = 1'b0;
    res_o.result_name = '0;
    res_o.set_outcome = OUT_NONE;
    wr_key            = '0;
    wr_disp           = '0;
    cnt_d             = cnt_q;
    rp_d              = rp_q;
    if (item_i.op == OP_LOOKUP) begin
      res_o.found = |key_hit;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (key_first[i]) begin
          res_o.result_name = res_o.result_name | disp_q[i];
        end
      end
    end else if ((item_i.key != '0) && (item_i.disp != '0)) begin
      if (|disp_hit) begin
        res_o.set_outcome = OUT_RENAMED;
        wr_disp           = disp_first;
      end else if (|key_hit) begin
        res_o.set_outcome = OUT_UPDATED;
        wr_disp           = key_first;
      end else begin
        wr_key  = ins_sel;
        wr_disp = ins_sel;
        if (!full) begin
          res_o.set_outcome = OUT_APPENDED;
          cnt_d             = cnt_q + CNT_W'(1);
        end else begin
          res_o.set_outcome = OUT_REPLACED;
          rp_d = (rp_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : rp_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rp_q  <= '0;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
      rp_q  <= rp_d;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_ent
    always_ff @(posedge clk_i) begin
      if (fire_i && wr_key[g]) begin
        key_q[g] <= new_key;
      end
      if (fire_i && wr_disp[g]) begin
        disp_q[g] <= new_disp;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_replace_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (res_o.set_outcome == OUT_REPLACED)) |-> full)
    else $error("replace while table not full");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (res_o.set_outcome == OUT_APPENDED)) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not grow count");

  a_rp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && (res_o.set_outcome == OUT_REPLACED)) |=> $stable(rp_q))
    else $error("replace pointer moved without replace");

  a_lookup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.op == OP_LOOKUP) |-> (res_o.set_outcome == OUT_NONE) && (wr_key == '0)
                                 && (wr_disp == '0))
    else $error("lookup modified table");

endmodule

// ----- rtl/core/nat_out_reg.sv -----
// nat_out_reg: result word register towards the output channel.
// Depends on nat_pkg.
module nat_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  nat_pkg::result_t           res_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic                       found_o,
  output logic [nat_pkg::NAME_W-1:0] result_name_o,
  output logic [2:0]                 set_outcome_o
);
  import nat_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign ready_o = !vld_q || !stall_i;

  always_comb begin
    vld_d = vld_q;
    if (take_i) begin
      vld_d = 1'b1;
    end else if (!stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o       = vld_q;
  assign found_o       = res_q.found;
  assign result_name_o = res_q.result_name;
  assign set_outcome_o = res_q.set_outcome;

endmodule

// ----- rtl/core/name_alias_table.sv -----
// name_alias_table: top level of the name alias table.
// Depends on nat_pkg, nat_in_reg, nat_table and nat_out_reg.
//
// Maps short names (up to NAME_BYTES-1 characters, first character in bits 7:0,
// zero padded) to display names. One word is taken per cycle while the output
// is not stalled. An accepted word is held in the input register, then makes
// one pass through the table compare into the result register, which drives
// the output. The rate is set by that single pass, which compares the key
// against every stored key and display at once and writes the chosen entry in
// the same cycle. A stalled result holds the input register, and the stall
// reaches in_stall_o in the same cycle. Reset clears the valid flags, the fill
// count and the replace pointer; table entries are not cleared, and no clearing
// pass is needed.
module name_alias_table #(
  parameter int unsigned TABLE_ENTRIES = nat_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned NAME_BYTES    = nat_pkg::NAME_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [nat_pkg::NAME_W-1:0] key_name_i,
  input  logic [nat_pkg::NAME_W-1:0] display_name_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [nat_pkg::NAME_W-1:0] result_name_o,
  output logic [2:0]                 set_outcome_o
);
  import nat_pkg::*;

  item_t   item;
  result_t res;
  logic    item_vld, out_ready, fire;

  assign fire = item_vld && out_ready;

  nat_in_reg u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .stall_o        (in_stall_o),
    .operation_i    (operation_i),
    .key_name_i     (key_name_i),
    .display_name_i (display_name_i),
    .take_i         (fire),
    .vld_o          (item_vld),
    .item_o         (item)
  );

  nat_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  nat_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (fire),
    .res_i         (res),
    .ready_o       (out_ready),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .found_o       (found_o),
    .result_name_o (result_name_o),
    .set_outcome_o (set_outcome_o)
  );

endmodule
